@@ rtl/gps_pkg.sv @@
// ----------------------------------------------------------------------------
// gps_pkg
// Types, widths and constants shared by the polar Gaussian sampler.
// ----------------------------------------------------------------------------
package gps_pkg;

  localparam int UNIFORM_BITS = 16;
  localparam int FRAC_BITS    = UNIFORM_BITS - 1;
  localparam int SQ_W         = 2 * UNIFORM_BITS;
  localparam int SQ_PW        = $clog2(SQ_W);

  localparam int LOG_FRAC     = 24;
  localparam int NORM_W       = 31;
  localparam int NL_W         = 30;
  localparam int L_W          = 31;
  localparam int LN_SHIFT     = 30;
  localparam logic [L_W-1:0] TWO_LN2_Q30 = 31'd1488522236;

  localparam int DEN_W        = 32;
  localparam int Q_W          = DEN_W + 1;
  localparam int PROD_W       = Q_W + L_W;
  localparam int ROOT_STEPS   = PROD_W / 2;
  localparam int ROOT_W       = PROD_W / 2;

  localparam int SCALE_W      = 16;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 16'd256;
  localparam int DEV_W        = 24;
  localparam int MAG_W        = DEV_W + 1;
  localparam int SP_W         = ROOT_W + SCALE_W + 1;
  localparam int ROUND_SHIFT  = 24;

  typedef struct packed {
    logic signed [UNIFORM_BITS-1:0] u_sample;
    logic signed [UNIFORM_BITS-1:0] v_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [DEV_W-1:0] deviate;
    logic                    last;
  } out_word_t;

  typedef struct packed {
    logic [SQ_W-1:0] usq;
    logic [SQ_W-1:0] vsq;
    logic [SQ_W-1:0] sum;
    logic            neg_u;
    logic            neg_v;
  } gps_side_t;

  function automatic logic [SQ_PW-1:0] top_bit(logic [SQ_W-1:0] x);
    logic [SQ_PW-1:0] p;
    p = '0;
    for (int i = 0; i < SQ_W; i++) begin
      if (x[i]) begin
        p = SQ_PW'(i);
      end
    end
    return p;
  endfunction

endpackage

@@ rtl/gps_log.sv @@
// ----------------------------------------------------------------------------
// gps_log
// Pipelined -2 ln(s): normalize, one squaring step per log bit, scale by 2 ln 2.
// ----------------------------------------------------------------------------
module gps_log import gps_pkg::*; (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            vld_i,
  input  logic [SQ_W-1:0] s_i,
  input  gps_side_t       side_i,
  output logic            vld_o,
  output logic [L_W-1:0]  l_o,
  output gps_side_t       side_o
);

  localparam int LAT = LOG_FRAC + 4;

  logic                    vld_r  [LAT];
  gps_side_t               side_r [LAT];
  logic [SQ_W-1:0]         s_r;
  logic [SQ_PW-1:0]        p_r;
  logic [NORM_W-1:0]       x_r    [LOG_FRAC+1];
  logic [LOG_FRAC-1:0]     fr_r   [LOG_FRAC+1];
  logic [SQ_PW-1:0]        pp_r   [LOG_FRAC+1];
  logic [NORM_W-1:0]       x0_nxt;
  logic [NORM_W-1:0]       x_nxt  [1:LOG_FRAC];
  logic [LOG_FRAC-1:0]     fr_nxt [1:LOG_FRAC];
  logic [2*NORM_W-1:0]     sq_w   [1:LOG_FRAC];
  logic [SQ_W+NORM_W-1:0]  ext;
  logic [NL_W-1:0]         nl_r, nl_nxt;
  logic [NL_W+L_W-1:0]     prod;
  logic [L_W-1:0]          l_r, l_nxt;

  always_comb begin
    ext = (SQ_W+NORM_W)'(s_r);
    if (int'(p_r) > NORM_W - 1) begin
      ext = ext >> (int'(p_r) - (NORM_W - 1));
    end else begin
      ext = ext << ((NORM_W - 1) - int'(p_r));
    end
    x0_nxt = ext[NORM_W-1:0];
    for (int i = 1; i <= LOG_FRAC; i++) begin
      sq_w[i] = (2*NORM_W)'(x_r[i-1]) * (2*NORM_W)'(x_r[i-1]);
      if (sq_w[i][2*NORM_W-1]) begin
        x_nxt[i]  = sq_w[i][2*NORM_W-1:NORM_W];
        fr_nxt[i] = fr_r[i-1] | (LOG_FRAC'(1) << (LOG_FRAC - i));
      end else begin
        x_nxt[i]  = sq_w[i][2*NORM_W-2:NORM_W-1];
        fr_nxt[i] = fr_r[i-1];
      end
    end
    nl_nxt = (NL_W'(2 * FRAC_BITS - int'(pp_r[LOG_FRAC])) << LOG_FRAC)
             - NL_W'(fr_r[LOG_FRAC]);
    prod   = (NL_W+L_W)'(nl_r) * (NL_W+L_W)'(TWO_LN2_Q30);
    l_nxt  = prod[LN_SHIFT+L_W-1:LN_SHIFT];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        vld_r[i] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= vld_i;
      for (int i = 1; i < LAT; i++) begin
        vld_r[i] <= vld_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_i;
      for (int i = 1; i < LAT; i++) begin
        side_r[i] <= side_r[i-1];
      end
      s_r      <= s_i;
      p_r      <= top_bit(s_i);
      x_r[0]   <= x0_nxt;
      fr_r[0]  <= '0;
      pp_r[0]  <= p_r;
      for (int i = 1; i <= LOG_FRAC; i++) begin
        x_r[i]  <= x_nxt[i];
        fr_r[i] <= fr_nxt[i];
        pp_r[i] <= pp_r[i-1];
      end
      nl_r <= nl_nxt;
      l_r  <= l_nxt;
    end
  end

  assign vld_o  = vld_r[LAT-1];
  assign side_o = side_r[LAT-1];
  assign l_o    = l_r;

endmodule

@@ rtl/gps_lane.sv @@
// ----------------------------------------------------------------------------
// gps_lane
// One deviate: a^2/s by long division, times -2 ln s, square root, scaling.
// ----------------------------------------------------------------------------
module gps_lane import gps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               vld_i,
  input  logic [L_W-1:0]     l_i,
  input  logic [SQ_W-1:0]    a2_i,
  input  logic [SQ_W-1:0]    s_i,
  input  logic               neg_i,
  input  logic [SCALE_W-1:0] scale_i,
  output logic               vld_o,
  output logic [DEV_W-1:0]   dev_o
);

  localparam int QB = Q_W;
  localparam int RT = ROOT_STEPS;

  logic [SQ_PW-1:0]   sp_top;
  int                 k;
  logic [SQ_W-1:0]    num_sh, den_sh;

  logic               pv_r, pneg_r;
  logic [DEN_W-1:0]   pnum_r, pden_r;
  logic [L_W-1:0]     pl_r;

  logic               dv_r   [QB];
  logic [DEN_W-1:0]   rem_r  [QB];
  logic [Q_W-1:0]     quo_r  [QB];
  logic [DEN_W-1:0]   dden_r [QB];
  logic [L_W-1:0]     dl_r   [QB];
  logic               dneg_r [QB];
  logic [DEN_W-1:0]   rem_nxt [QB];
  logic [Q_W-1:0]     quo_nxt [QB];
  logic [DEN_W:0]     twice   [1:QB-1];
  logic               ge      [QB];

  logic               mv_r, mneg_r;
  logic [PROD_W-1:0]  m_r;

  logic               sv_r   [RT];
  logic               sneg_r [RT];
  logic [PROD_W-1:0]  n_r    [RT];
  logic [PROD_W-1:0]  r_r    [RT];
  logic [PROD_W-1:0]  n_nxt  [RT];
  logic [PROD_W-1:0]  r_nxt  [RT];
  logic [PROD_W-1:0]  n_in, r_in, bitv, trial;

  logic               gv_r, gneg_r;
  logic [SP_W-1:0]    sp;
  logic [MAG_W-1:0]   mg_r;
  logic [MAG_W-1:0]   lim;

  logic               ov_r;
  logic [DEV_W-1:0]   dev_r, dev_nxt;

  always_comb begin
    sp_top = top_bit(s_i);
    k      = 0;
    if (int'(sp_top) > DEN_W - 1) begin
      k = int'(sp_top) - (DEN_W - 1);
    end
    num_sh = a2_i >> k;
    den_sh = s_i >> k;
  end

  always_comb begin
    ge[0]      = pnum_r >= pden_r;
    rem_nxt[0] = ge[0] ? (pnum_r - pden_r) : pnum_r;
    quo_nxt[0] = Q_W'(ge[0]);
    for (int i = 1; i < QB; i++) begin
      twice[i]   = {rem_r[i-1], 1'b0};
      ge[i]      = twice[i] >= {1'b0, dden_r[i-1]};
      rem_nxt[i] = ge[i] ? DEN_W'(twice[i] - {1'b0, dden_r[i-1]}) : twice[i][DEN_W-1:0];
      quo_nxt[i] = {quo_r[i-1][Q_W-2:0], ge[i]};
    end
  end

  always_comb begin
    n_in  = '0;
    r_in  = '0;
    bitv  = '0;
    trial = '0;
    for (int j = 0; j < RT; j++) begin
      n_in  = (j == 0) ? m_r : n_r[j-1 < 0 ? 0 : j-1];
      r_in  = (j == 0) ? '0  : r_r[j-1 < 0 ? 0 : j-1];
      bitv  = PROD_W'(1) << (PROD_W - 2 - 2 * j);
      trial = r_in + bitv;
      if (n_in >= trial) begin
        n_nxt[j] = n_in - trial;
        r_nxt[j] = (r_in >> 1) + bitv;
      end else begin
        n_nxt[j] = n_in;
        r_nxt[j] = r_in >> 1;
      end
    end
  end

  always_comb begin
    sp = SP_W'(r_r[RT-1][ROOT_W-1:0]) * SP_W'(scale_i) + (SP_W'(1) << (ROUND_SHIFT - 1));
    if (gneg_r) begin
      lim = (mg_r > (MAG_W'(1) << (DEV_W - 1))) ? (MAG_W'(1) << (DEV_W - 1)) : mg_r;
      dev_nxt = DEV_W'(MAG_W'(0) - lim);
    end else begin
      lim = (mg_r > ((MAG_W'(1) << (DEV_W - 1)) - MAG_W'(1)))
            ? ((MAG_W'(1) << (DEV_W - 1)) - MAG_W'(1)) : mg_r;
      dev_nxt = lim[DEV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
      mv_r <= 1'b0;
      gv_r <= 1'b0;
      ov_r <= 1'b0;
      for (int i = 0; i < QB; i++) begin
        dv_r[i] <= 1'b0;
      end
      for (int j = 0; j < RT; j++) begin
        sv_r[j] <= 1'b0;
      end
    end else if (en) begin
      pv_r    <= vld_i;
      dv_r[0] <= pv_r;
      for (int i = 1; i < QB; i++) begin
        dv_r[i] <= dv_r[i-1];
      end
      mv_r    <= dv_r[QB-1];
      sv_r[0] <= mv_r;
      for (int j = 1; j < RT; j++) begin
        sv_r[j] <= sv_r[j-1];
      end
      gv_r <= sv_r[RT-1];
      ov_r <= gv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pnum_r <= num_sh[DEN_W-1:0];
      pden_r <= den_sh[DEN_W-1:0];
      pl_r   <= l_i;
      pneg_r <= neg_i;
      rem_r[0]  <= rem_nxt[0];
      quo_r[0]  <= quo_nxt[0];
      dden_r[0] <= pden_r;
      dl_r[0]   <= pl_r;
      dneg_r[0] <= pneg_r;
      for (int i = 1; i < QB; i++) begin
        rem_r[i]  <= rem_nxt[i];
        quo_r[i]  <= quo_nxt[i];
        dden_r[i] <= dden_r[i-1];
        dl_r[i]   <= dl_r[i-1];
        dneg_r[i] <= dneg_r[i-1];
      end
      m_r    <= PROD_W'(quo_r[QB-1]) * PROD_W'(dl_r[QB-1]);
      mneg_r <= dneg_r[QB-1];
      sneg_r[0] <= mneg_r;
      for (int j = 0; j < RT; j++) begin
        n_r[j] <= n_nxt[j];
        r_r[j] <= r_nxt[j];
      end
      for (int j = 1; j < RT; j++) begin
        sneg_r[j] <= sneg_r[j-1];
      end
      mg_r   <= sp[ROUND_SHIFT+MAG_W-1:ROUND_SHIFT];
      gneg_r <= sneg_r[RT-1];
      dev_r  <= dev_nxt;
    end
  end

  assign vld_o = ov_r;
  assign dev_o = dev_r;

endmodule

@@ rtl/gaussian_polar_sampler.sv @@
// ----------------------------------------------------------------------------
// gaussian_polar_sampler
// Polar-method normal deviate generator fed by pairs of uniform values.
// ----------------------------------------------------------------------------
// The input channel takes one word per pair (u_sample, v_sample, signed Q1.15)
// on in_valid/in_stall. The result channel gives two words per accepted pair
// on out_valid/out_stall: the u deviate, then the v deviate with last set.
// Deviates are signed Q12.12 and saturate. A pair with s = 0 or s >= 1 is
// dropped and yields no word.
// The scale register (unsigned Q8.8) is written over cfg_valid/cfg_ready,
// which is always ready; write it only while no pair is in flight.
// The latency from input to the first deviate is set by the 24 log squaring
// steps, the 33 step divider and the 32 step square root.
// A pair may enter every cycle while the pipeline is not held, but each kept
// pair gives two output words, and the pipeline holds while the first is sent.
// Reset clears every valid bit and loads scale with 1.0. The whole pipeline
// holds and in_stall rises while the u deviate or a stalled v deviate waits.
// ----------------------------------------------------------------------------
module gaussian_polar_sampler import gps_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  in_word_t           in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output out_word_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [SCALE_W-1:0] cfg_data
);

  logic                    en;
  logic [SCALE_W-1:0]      scale_r;

  logic                    st0_vld_r, st1_vld_r, st2_vld_r;
  in_word_t                in_r;
  logic [UNIFORM_BITS-1:0] ua, va;
  logic [SQ_W-1:0]         usq_r, vsq_r;
  logic                    negu_r, negv_r;
  logic [SQ_W-1:0]         sum_nxt;
  logic                    keep;
  gps_side_t               side_r;

  logic                    log_vld;
  logic [L_W-1:0]          log_l;
  gps_side_t               log_side;

  logic                    u_vld, v_vld;
  logic [DEV_W-1:0]        u_dev, v_dev;

  logic                    pair_vld_r, half_r;
  logic [DEV_W-1:0]        du_r, dv_r;

  assign en        = !pair_vld_r || (half_r && !out_stall);
  assign in_stall  = !en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      scale_r <= cfg_data;
    end
  end

  always_comb begin
    ua = in_r.u_sample[UNIFORM_BITS-1] ? UNIFORM_BITS'(-in_r.u_sample)
                                        : UNIFORM_BITS'(in_r.u_sample);
    va = in_r.v_sample[UNIFORM_BITS-1] ? UNIFORM_BITS'(-in_r.v_sample)
                                        : UNIFORM_BITS'(in_r.v_sample);
    sum_nxt = usq_r + vsq_r;
    keep    = (sum_nxt != '0) && ((sum_nxt >> (2 * FRAC_BITS)) == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st0_vld_r <= 1'b0;
      st1_vld_r <= 1'b0;
      st2_vld_r <= 1'b0;
    end else if (en) begin
      st0_vld_r <= in_valid;
      st1_vld_r <= st0_vld_r;
      st2_vld_r <= st1_vld_r && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      in_r         <= in_data;
      usq_r        <= SQ_W'(ua) * SQ_W'(ua);
      vsq_r        <= SQ_W'(va) * SQ_W'(va);
      negu_r       <= in_r.u_sample[UNIFORM_BITS-1];
      negv_r       <= in_r.v_sample[UNIFORM_BITS-1];
      side_r.usq   <= usq_r;
      side_r.vsq   <= vsq_r;
      side_r.sum   <= sum_nxt;
      side_r.neg_u <= negu_r;
      side_r.neg_v <= negv_r;
    end
  end

  gps_log u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (st2_vld_r),
    .s_i    (side_r.sum),
    .side_i (side_r),
    .vld_o  (log_vld),
    .l_o    (log_l),
    .side_o (log_side)
  );

  gps_lane u_lane_u (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (log_vld),
    .l_i     (log_l),
    .a2_i    (log_side.usq),
    .s_i     (log_side.sum),
    .neg_i   (log_side.neg_u),
    .scale_i (scale_r),
    .vld_o   (u_vld),
    .dev_o   (u_dev)
  );

  gps_lane u_lane_v (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (log_vld),
    .l_i     (log_l),
    .a2_i    (log_side.vsq),
    .s_i     (log_side.sum),
    .neg_i   (log_side.neg_v),
    .scale_i (scale_r),
    .vld_o   (v_vld),
    .dev_o   (v_dev)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pair_vld_r <= 1'b0;
      half_r     <= 1'b0;
    end else if (en) begin
      pair_vld_r <= u_vld && v_vld;
      half_r     <= 1'b0;
    end else if (!out_stall) begin
      half_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      du_r <= u_dev;
      dv_r <= v_dev;
    end
  end

  assign out_valid        = pair_vld_r;
  assign out_data.deviate = half_r ? dv_r : du_r;
  assign out_data.last    = half_r;

  a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_data.last |=> out_valid && out_data.last)
    else $error("second word of a pair did not follow the first");

  a_stall_reason: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && (out_stall || !out_data.last))
    else $error("input stalled without a pending output word");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Checks the polar Gaussian sampler against a bit-exact predictor.
// Directed and random uniform pairs are sent under random idling on both
// channels, across several scale settings, and every deviate is compared.
// ----------------------------------------------------------------------------
module tb_top;
  import gps_pkg::*;

  class deviate_board;
    logic [15:0]  scale_q88;
    out_word_t    pending[$];
    int           errors;
    int           pairs_seen;
    int           words_seen;

    function new();
      scale_q88 = SCALE_RESET;
      errors = 0;
      pairs_seen = 0;
      words_seen = 0;
    endfunction

    function automatic logic [63:0] root64(logic [63:0] n);
      logic [63:0] r;
      logic [63:0] b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
        if (n >= r + b) begin
          n = n - (r + b);
          r = (r >> 1) + b;
        end else begin
          r = r >> 1;
        end
        b = b >> 2;
      end
      return r;
    endfunction

    function automatic logic [63:0] log_term(logic [63:0] sq);
      int p;
      logic [63:0] x;
      logic [63:0] frac;
      logic [63:0] nl;
      p = 0;
      for (int i = 0; i < 64; i++) if (sq[i]) p = i;
      x = (p > 30) ? (sq >> (p - 30)) : (sq << (30 - p));
      frac = 0;
      for (int i = 1; i <= 24; i++) begin
        x = (x * x) >> 30;
        if (x >= (64'd1 << 31)) begin
          x = x >> 1;
          frac[24-i] = 1'b1;
        end
      end
      nl = (64'(30 - p) << 24) - frac;
      return (nl * 64'd1488522236) >> 30;
    endfunction

    function automatic logic [23:0] one_deviate(logic neg, logic [63:0] a2,
                                                logic [63:0] sq, logic [63:0] lq);
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] q;
      logic [63:0] mag;
      num = a2;
      den = sq;
      while (den >= (64'd1 << 32)) begin
        den = den >> 1;
        num = num >> 1;
      end
      q = (num << 32) / den;
      mag = (root64(q * lq) * scale_q88 + (64'd1 << 23)) >> 24;
      if (neg) begin
        if (mag > 64'd8388608) mag = 64'd8388608;
        return 24'(64'd0 - mag);
      end
      if (mag > 64'd8388607) mag = 64'd8388607;
      return mag[23:0];
    endfunction

    function void note_pair(in_word_t w);
      logic [63:0] ua;
      logic [63:0] va;
      logic [63:0] sq;
      logic [63:0] lq;
      out_word_t e;
      ua = (w.u_sample < 0) ? 64'(-int'(w.u_sample)) : 64'(int'(w.u_sample));
      va = (w.v_sample < 0) ? 64'(-int'(w.v_sample)) : 64'(int'(w.v_sample));
      sq = ua * ua + va * va;
      pairs_seen++;
      if (sq == 0 || sq >= (64'd1 << 30)) return;
      lq = log_term(sq);
      e.deviate = one_deviate(w.u_sample < 0, ua * ua, sq, lq);
      e.last = 1'b0;
      pending.push_back(e);
      e.deviate = one_deviate(w.v_sample < 0, va * va, sq, lq);
      e.last = 1'b1;
      pending.push_back(e);
    endfunction

    task check_word(out_word_t got);
      out_word_t e;
      words_seen++;
      if (pending.size() == 0) begin
        report("unexpected word", got.deviate, 0);
        return;
      end
      e = pending.pop_front();
      if (got.deviate !== e.deviate) report("deviate", got.deviate, e.deviate);
      if (got.last !== e.last) report("last", got.last, e.last);
    endtask

    task report(string what, logic [23:0] got, logic [23:0] want);
      errors++;
      $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    endtask
  endclass

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_word_t out_data;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [SCALE_W-1:0] cfg_data;

  deviate_board board;
  int  idle_cycles;
  int  rx_wait;
  bit  out_fire;
  bit  sending_done;
  bit  timed_out;

  gaussian_polar_sampler i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      idle_cycles <= 0;
      out_fire <= 1'b0;
    end else begin
      if ((in_valid && !in_stall) ||
          (out_valid && !out_stall && board.pending.size() != 0))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      out_fire <= out_valid && !out_stall;
      if (in_valid && !in_stall) board.note_pair(in_data);
      if (out_valid && !out_stall) board.check_word(out_data);
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      rx_wait = $urandom_range(0, 7);
      out_stall <= 1'b0;
    end else begin
      if (out_fire) rx_wait = $urandom_range(0, 7);
      if (rx_wait != 0) begin
        rx_wait = rx_wait - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic send_pair(logic [15:0] u, logic [15:0] v, bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data.u_sample <= u;
    in_data.v_sample <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic write_scale(logic [15:0] value);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    board.scale_q88 = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_phase(int count);
    logic [15:0] u;
    logic [15:0] v;
    bit burst;
    for (int i = 0; i < count; i++) begin
      u = $urandom;
      v = $urandom;
      if ($urandom_range(0, 3) != 0) begin
        u = $urandom_range(0, 2) == 0 ? 16'($signed(u) >>> $urandom_range(1, 8)) : u;
        v = $urandom_range(0, 2) == 0 ? 16'($signed(v) >>> $urandom_range(1, 8)) : v;
      end
      burst = (i % 64) < 16;
      send_pair(u, v, burst);
    end
  endtask

  initial begin
    board = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    sending_done = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_pair(16'h0000, 16'h0000, 0);
    send_pair(16'h8000, 16'h0000, 0);
    send_pair(16'h0000, 16'h8000, 0);
    send_pair(16'h7fff, 16'h0000, 0);
    send_pair(16'h0000, 16'h7fff, 0);
    send_pair(16'h0001, 16'h0000, 0);
    send_pair(16'h0000, 16'hffff, 0);
    send_pair(16'h0001, 16'hffff, 1);
    send_pair(16'h5a82, 16'h5a82, 1);
    send_pair(16'h5a81, 16'ha57f, 1);
    send_pair(16'hc000, 16'h4000, 0);
    send_pair(16'h7fff, 16'h7fff, 0);
    send_pair(16'h8001, 16'h0001, 0);
    send_pair(16'h2000, 16'he000, 0);
    wait_drained();

    write_scale(16'hffff);
    send_pair(16'h0001, 16'h0000, 0);
    send_pair(16'hffff, 16'h0001, 0);
    send_pair(16'h7ffe, 16'h0001, 0);
    send_pair(16'h0001, 16'h8001, 0);
    random_phase(150);
    wait_drained();

    write_scale(16'h0000);
    random_phase(100);
    wait_drained();

    write_scale(16'h0100);
    random_phase(200);
    wait_drained();

    write_scale(16'($urandom));
    random_phase(230);
    wait_drained();

    sending_done = 1;
  end

  initial begin
    wait (sending_done || timed_out);
    if (!timed_out) begin
      $display("Sent %0d pairs and checked %0d deviates over five scale settings.",
               board.pairs_seen, board.words_seen);
      if (board.errors == 0 && board.pending.size() == 0) begin
        $display("RESULT: OK");
      end else begin
        $display("RESULT: ERROR");
      end
      $finish;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles > 5000 && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired with %0d deviates outstanding", board.pending.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end
endmodule

@@ sim.f @@
rtl/gps_pkg.sv
rtl/gps_log.sv
rtl/gps_lane.sv
rtl/gaussian_polar_sampler.sv
verif/tb_top.sv
